// ===== hw/rtl/lgs_pkg.sv =====
package lgs_pkg;

	// Fixed field widths of the result items and the register port
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned POS_W     = 10;
	localparam int unsigned DEF_MAX_W = 1024;
	localparam int unsigned DEF_MAX_H = 1024;
	localparam int unsigned DIM_RESET = 1024;
	localparam int unsigned DIM_MIN   = 3;

	// Result queue
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned NRES   = 3;

	// Register indexes
	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Position of an item within the board
	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic c_last;
		logic r_last;
	} pos_flags_t;

	// One result item
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             alive;
		logic             done;
		logic             last;
	} res_t;

	// Clamp a dimension to [3, maxv] and return its last index
	function automatic int unsigned last_index(logic [CFG_W-1:0] v, int unsigned maxv);
		int unsigned d;
		d = 32'(v);
		if (d < DIM_MIN) begin
			d = DIM_MIN;
		end else if (d > maxv) begin
			d = maxv;
		end
		return d - 1;
	endfunction

endpackage

// ===== hw/rtl/life_generation_stencil.sv =====
// Streaming Life (B3/S23) generation unit.
// Input channel: one cell per item in raster order (row 0 first, columns left
// to right), handshake in_valid/in_stall. Output channel: result items with
// row, column, next-generation value, frame_done on the bottom-right cell and
// run_last on the last result caused by each input item.
// Each input yields up to three results: the cell one row and one column back,
// the previous row's last column when the input closes a row, and on the last
// row the input cell itself. Inputs of row 0 yield nothing.
// Each item is registered into stage 1 while its line store read completes; its
// results are then written to the result queue and offered from its head.
// Throughput: one item per cycle while the result queue has room; the single
// port pair of the line store and one output per cycle set this figure, so
// items that cause two or three results leave as that many separate outputs.
// When out_stall is held, the eight-entry result queue fills and in_stall rises.
// Writing board_width or board_height clamps it to [3, MAX] and restarts the
// frame at cell (0,0). Reset selects a 1024 by 1024 board; line store
// contents need no clearing, since they only feed border cells.
module life_generation_stencil import lgs_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_W,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_H
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cell_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             next_alive,
	output logic             frame_done,
	output logic             run_last,
	input  logic             cfg_we,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          in_acc;
	logic          room;

	logic          valid_s1;
	logic          cell_s1;
	pos_flags_t    flags_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	logic [1:0]      rdata;
	logic [1:0]      wdata;
	logic [NRES-1:0] res_v;
	res_t            res [NRES];
	res_t            head;
	logic            pop;

	assign in_stall = !room;
	assign in_acc   = in_valid && !in_stall;

	// Latch clamped board size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(last_index(CFG_W'(DIM_RESET), MAX_WIDTH));
			last_row_q <= RW'(last_index(CFG_W'(DIM_RESET), MAX_HEIGHT));
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  last_col_q <= CW'(last_index(cfg_wdata, MAX_WIDTH));
				REG_HEIGHT: last_row_q <= RW'(last_index(cfg_wdata, MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	// Track the raster position of the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: item waits for its line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cell_s1         <= cell_in;
			row_s1          <= row_q;
			col_s1          <= col_q;
			flags_s1.r_ge1  <= (row_q != '0);
			flags_s1.r_ge2  <= (row_q > RW'(1));
			flags_s1.c_ge1  <= (col_q != '0);
			flags_s1.c_ge2  <= (col_q > CW'(1));
			flags_s1.c_last <= (col_q == last_col_q);
			flags_s1.r_last <= (row_q == last_row_q);
		end
	end

	// Two line stores packed side by side in one memory
	lgs_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (rdata)
	);

	lgs_stencil #(
		.RW(RW),
		.CW(CW)
	) u_stencil (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_we),
		.valid_s1 (valid_s1),
		.cell_s1  (cell_s1),
		.flags_s1 (flags_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.rdata    (rdata),
		.wdata    (wdata),
		.res_v    (res_v),
		.res      (res)
	);

	assign pop = out_valid && !out_stall;

	lgs_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_v   (res_v),
		.push_res (res),
		.pend     (valid_s1),
		.pop      (pop),
		.head     (head),
		.nonempty (out_valid),
		.room     (room)
	);

	// Drive the result fields from the queue head
	assign out_row    = head.row;
	assign out_col    = head.col;
	assign next_alive = head.alive;
	assign frame_done = head.done;
	assign run_last   = head.last;

endmodule

// ===== hw/rtl/lgs_ram.sv =====
module lgs_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lgs_stencil.sv =====
module lgs_stencil import lgs_pkg::*; #(
	parameter int unsigned RW = 10,
	parameter int unsigned CW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          valid_s1,
	input  logic          cell_s1,
	input  pos_flags_t    flags_s1,
	input  logic [RW-1:0] row_s1,
	input  logic [CW-1:0] col_s1,
	input  logic [1:0]    rdata,
	output logic [1:0]    wdata,
	output logic [NRES-1:0] res_v,
	output res_t          res [NRES]
);

	logic [8:0] win_q;
	logic [8:0] win_next;
	logic       up1;
	logic       up2;
	logic [3:0] ncount;
	logic       rule_alive;
	logic       alive0;
	logic [POS_W-1:0] row_cur;
	logic [POS_W-1:0] row_prev;
	logic [POS_W-1:0] col_cur;
	logic [POS_W-1:0] col_prev;

	// Line store read: bit 0 two rows up, bit 1 one row up
	assign up2   = rdata[0];
	assign up1   = rdata[1];
	// Age the column down one row
	assign wdata = {cell_s1, up1};

	assign win_next = {cell_s1, up1, up2, win_q[8:3]};

	// Count the eight neighbours around the window center
	always_comb begin
		ncount = '0;
		for (int b = 0; b < 9; b++) begin
			if (b != 4) begin
				ncount = ncount + 4'(win_next[b]);
			end
		end
	end

	always_comb begin
		rule_alive = 1'b0;
		if (ncount == 4'd3) begin
			rule_alive = 1'b1;
		end else if (ncount == 4'd2) begin
			rule_alive = win_next[4];
		end
	end

	// Border cells pass through
	assign alive0 = (flags_s1.r_ge2 && flags_s1.c_ge2) ? rule_alive : win_next[4];

	assign row_cur  = POS_W'(32'(row_s1));
	assign row_prev = POS_W'(32'(row_s1) - 32'd1);
	assign col_cur  = POS_W'(32'(col_s1));
	assign col_prev = POS_W'(32'(col_s1) - 32'd1);

	// Build the up to three results of this item
	always_comb begin
		res_v[0] = valid_s1 && flags_s1.r_ge1 && flags_s1.c_ge1;
		res_v[1] = valid_s1 && flags_s1.r_ge1 && flags_s1.c_last;
		res_v[2] = valid_s1 && flags_s1.r_last;

		res[0] = '{row: row_prev, col: col_prev, alive: alive0, done: 1'b0,
			last: !res_v[1] && !res_v[2]};
		res[1] = '{row: row_prev, col: col_cur, alive: up1, done: 1'b0,
			last: !res_v[2]};
		res[2] = '{row: row_cur, col: col_cur, alive: cell_s1, done: flags_s1.c_last,
			last: 1'b1};
	end

	// Shift the window one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (clear) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

endmodule

// ===== hw/rtl/lgs_resq.sv =====
module lgs_resq import lgs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NRES-1:0] push_v,
	input  res_t            push_res [NRES],
	input  logic            pend,
	input  logic            pop,
	output res_t            head,
	output logic            nonempty,
	output logic            room
);

	res_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	res_t         packed_res [NRES];
	logic [1:0]   npush;

	// Pack the valid results to the front, keeping their order
	always_comb begin
		npush = '0;
		for (int i = 0; i < NRES; i++) begin
			packed_res[i] = push_res[i];
		end
		for (int i = 0; i < NRES; i++) begin
			if (push_v[i]) begin
				packed_res[npush] = push_res[i];
				npush = npush + 2'd1;
			end
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	// Room for the item in flight and one more
	assign room = (32'(count_q) + (pend ? 32'(NRES) : 32'd0)) <= 32'(QDEPTH - NRES);

	// Store the packed results
	always_ff @(posedge clk) begin
		for (int i = 0; i < NRES; i++) begin
			if (2'(i) < npush) begin
				mem_q[wr_ptr_q + QAW'(i)] <= packed_res[i];
			end
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(npush);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(npush) - (QAW+1)'(pop);
		end
	end

endmodule

// ===== sim/tb_life_generation_stencil.sv =====
`timescale 1ns / 1ps

module tb_life_generation_stencil import lgs_pkg::*; ;

	localparam int unsigned MAX_W         = DEF_MAX_W;
	localparam int unsigned MAX_H         = DEF_MAX_H;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned END_PAD       = 20;
	localparam int unsigned QUIET_LIMIT   = 400;
	localparam int unsigned RANDOM_CELLS  = 200;
	localparam int unsigned WIDE_CELLS    = 120;
	localparam int unsigned TALL_CELLS    = 90;

	typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_e;

	// One row of the directed plan: a register write or a cell, optionally with a
	// hand-written first result
	typedef struct {
		step_kind_e       kind;
		reg_idx_t         idx;
		logic [CFG_W-1:0] wdata;
		bit               cell_bit;
		bit               has_want;
		res_t             want;
	} plan_row_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic             cell_in    = 1'b0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic             next_alive;
	logic             frame_done;
	logic             run_last;
	logic             cfg_we     = 1'b0;
	reg_idx_t         cfg_index  = REG_WIDTH;
	logic [CFG_W-1:0] cfg_wdata  = '0;

	// Life generation state as the block should hold it
	logic [CFG_W-1:0] width_reg  = CFG_W'(DIM_RESET);
	logic [CFG_W-1:0] height_reg = CFG_W'(DIM_RESET);
	bit               older_row [MAX_W];
	bit               prior_row [MAX_W];
	bit [8:0]         window     = '0;
	int unsigned      row_pos    = 0;
	int unsigned      col_pos    = 0;

	res_t             awaited_results [$];
	bit               idle_on    = 1'b0;
	int unsigned      mismatch_count  = 0;
	int unsigned      results_checked = 0;
	int unsigned      cells_sent      = 0;
	int unsigned      settings_used   = 0;
	int unsigned      quiet_cycles    = 0;

	life_generation_stencil uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_in    (cell_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_row    (out_row),
		.out_col    (out_col),
		.next_alive (next_alive),
		.frame_done (frame_done),
		.run_last   (run_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] got,
			input logic [POS_W-1:0] want_v);
		if (got !== want_v) begin
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want_v));
		end
	endtask

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		if (32'(v) < DIM_MIN) begin
			return DIM_MIN;
		end
		if (32'(v) > maxv) begin
			return maxv;
		end
		return 32'(v);
	endfunction

	// Advance the board by one cell and queue the results it finishes
	function automatic int predict_cell_results(input bit cell_bit);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned tr;
		int unsigned tc;
		int unsigned n;
		bit          up2;
		bit          up1;
		bit          nx;
		res_t        batch [$];
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_H);
		r = row_pos;
		c = col_pos;
		up2 = older_row[c];
		up1 = prior_row[c];
		window = {cell_bit, up1, up2, window[8:3]};
		older_row[c] = up1;
		prior_row[c] = cell_bit;

		// cell one row and one column behind: apply B3/S23 away from the border
		if (r >= 1 && c >= 1) begin
			tr = r - 1;
			tc = c - 1;
			nx = window[4];
			if (tr >= 1 && tr + 2 <= h && tc >= 1 && tc + 2 <= w) begin
				n = 0;
				for (int b = 0; b < 9; b++) begin
					if (b != 4) begin
						n += window[b];
					end
				end
				if (n == 3) begin
					nx = 1'b1;
				end else if (n != 2) begin
					nx = 1'b0;
				end
			end
			batch.push_back('{row: POS_W'(tr), col: POS_W'(tc), alive: nx,
				done: 1'b0, last: 1'b0});
		end
		// row closed: last column of the row above
		if (r >= 1 && c + 1 == w) begin
			batch.push_back('{row: POS_W'(r - 1), col: POS_W'(c), alive: up1,
				done: 1'b0, last: 1'b0});
		end
		// bottom row passes straight through
		if (r + 1 == h) begin
			batch.push_back('{row: POS_W'(r), col: POS_W'(c), alive: cell_bit,
				done: (c + 1 == w), last: 1'b0});
		end
		if (batch.size() > 0) begin
			batch[batch.size() - 1].last = 1'b1;
		end
		foreach (batch[i]) begin
			awaited_results.push_back(batch[i]);
		end

		// advance raster position, wrap to a new board after the last cell
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		col_pos = c;
		row_pos = r;
		return batch.size();
	endfunction

	// Offer one cell after a random gap and hold it until taken
	task automatic send_cell(input bit cell_bit, input bit has_want, input res_t want);
		int unsigned gap;
		int          made;
		@(negedge clk);
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cell_in  <= cell_bit;
		do @(posedge clk); while (in_stall);
		made = predict_cell_results(cell_bit);
		if (has_want && made > 0) begin
			awaited_results[awaited_results.size() - made] = want;
		end
		cells_sent++;
	endtask

	// Drop valid and wait until every result is in and the pipeline is empty
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] wdata);
		settle_block();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wdata;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) begin
			width_reg = wdata;
		end else begin
			height_reg = wdata;
		end
		// a write restarts the frame; line stores keep their contents
		window  = '0;
		row_pos = 0;
		col_pos = 0;
		settings_used++;
	endtask

	// Set the board size, then stream cells of the given density
	task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
			input logic [1:0] which, input int unsigned n_cells,
			input int unsigned density, input bit pause_mid);
		if ($urandom_range(0, 1) == 0) begin
			if (which[0]) write_reg(REG_WIDTH, w_raw);
			if (which[1]) write_reg(REG_HEIGHT, h_raw);
		end else begin
			if (which[1]) write_reg(REG_HEIGHT, h_raw);
			if (which[0]) write_reg(REG_WIDTH, w_raw);
		end
		for (int unsigned i = 0; i < n_cells; i++) begin
			if (pause_mid && i == n_cells / 2) begin
				settle_block();
			end
			send_cell($urandom_range(0, 99) < density, 1'b0, '0);
		end
	endtask

	function automatic plan_row_t cell_row(input bit cell_bit);
		plan_row_t p;
		p = '{STEP_CELL, REG_WIDTH, '0, cell_bit, 1'b0, '0};
		return p;
	endfunction

	function automatic plan_row_t typed_row(input bit cell_bit, input res_t want);
		plan_row_t p;
		p = '{STEP_CELL, REG_WIDTH, '0, cell_bit, 1'b1, want};
		return p;
	endfunction

	function automatic plan_row_t write_row(input reg_idx_t idx,
			input logic [CFG_W-1:0] wdata);
		plan_row_t p;
		p = '{STEP_WRITE, idx, wdata, 1'b0, 1'b0, '0};
		return p;
	endfunction

	// Take results with random stall gaps
	initial begin : result_sink
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = idle_on ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result with the oldest awaited one; watch for a hang
	always @(posedge clk) begin : result_check
		res_t want;
		bit   moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result (%0d,%0d) with nothing awaited",
					out_row, out_col));
			end else begin
				want = awaited_results.pop_front();
				check_field("out_row", out_row, want.row);
				check_field("out_col", out_col, want.col);
				check_field("next_alive", POS_W'(next_alive), POS_W'(want.alive));
				check_field("frame_done", POS_W'(frame_done), POS_W'(want.done));
				check_field("run_last", POS_W'(run_last), POS_W'(want.last));
				results_checked++;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("hang: %0d cycles without a handshake, %0d results awaited",
				quiet_cycles, awaited_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t        plan [];
		logic [CFG_W-1:0] w_raw;
		logic [CFG_W-1:0] h_raw;
		logic [1:0]       which;
		int unsigned      area;
		int unsigned      n_cells;
		int unsigned      random_cells;
		int unsigned      phases;

		plan = '{
			// row 0 at the reset size: nothing comes out
			cell_row(1'b1), cell_row(1'b0),
			// sizes below the minimum act as 3 by 3
			write_row(REG_WIDTH, 11'd0), write_row(REG_HEIGHT, 11'd2),
			// dead centre with three live neighbours is born
			cell_row(1'b1), cell_row(1'b1), cell_row(1'b0),
			cell_row(1'b0), typed_row(1'b0, '{10'd0, 10'd0, 1'b1, 1'b0, 1'b1}),
			cell_row(1'b0),
			typed_row(1'b1, '{10'd2, 10'd0, 1'b1, 1'b0, 1'b1}), cell_row(1'b0),
			typed_row(1'b0, '{10'd1, 10'd1, 1'b1, 1'b0, 1'b0}),
			// next board after the wrap: live centre with two neighbours survives
			cell_row(1'b1), cell_row(1'b0), cell_row(1'b0),
			cell_row(1'b0), cell_row(1'b1), cell_row(1'b0),
			typed_row(1'b0, '{10'd2, 10'd0, 1'b0, 1'b0, 1'b1}), cell_row(1'b0),
			typed_row(1'b1, '{10'd1, 10'd1, 1'b1, 1'b0, 1'b0})
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed plan
		idle_on = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				send_cell(plan[i].cell_bit, plan[i].has_want, plan[i].want);
			end
		end

		// widest and tallest boards, the first rows of each
		idle_on = 1'b0;
		run_phase(11'd2047, 11'd3, 2'b11, WIDE_CELLS, 50, 1'b0);
		idle_on = 1'b1;
		run_phase(11'd0, 11'd1024, 2'b11, TALL_CELLS, 50, 1'b1);

		// random small boards, full frames mostly, some cut short
		random_cells = 0;
		phases = 0;
		while (random_cells < RANDOM_CELLS) begin
			w_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 12));
			h_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 8));
			case ($urandom_range(0, 5))
				0: which = 2'b01;
				1: which = 2'b10;
				default: which = 2'b11;
			endcase
			if (phases == 0) begin
				which = 2'b11;
			end
			area = clamp_dim(which[0] ? w_raw : width_reg, MAX_W)
				* clamp_dim(which[1] ? h_raw : height_reg, MAX_H);
			if (area <= 150 && $urandom_range(0, 2) != 0) begin
				n_cells = area * $urandom_range(1, 2);
			end else begin
				n_cells = $urandom_range(5, 60);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			run_phase(w_raw, h_raw, which, n_cells, $urandom_range(0, 4) * 25,
				phases == 0 || $urandom_range(0, 3) == 0);
			random_cells += n_cells;
			phases++;
		end

		settle_block();
		repeat (END_PAD) @(posedge clk);

		$display("streamed %0d cells over %0d size writes, boards from 3x3 to 1024 wide/tall",
			cells_sent, settings_used);
		$display("compared %0d results, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_ram.sv
hw/rtl/lgs_stencil.sv
hw/rtl/lgs_resq.sv
hw/rtl/life_generation_stencil.sv
sim/tb_life_generation_stencil.sv
